// ===== rtl/core/afac_pkg.sv =====
// afac_pkg: beat types, register and phase codes, saturation helpers
// for the axial force admittance controller
// depends on nothing
package afac_pkg;

	typedef struct packed {
		logic signed [23:0] force_x;
		logic signed [23:0] force_y;
		logic signed [23:0] force_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] cmd_vel_x;
		logic signed [31:0] cmd_vel_y;
		logic signed [31:0] cmd_vel_z;
	} out_beat_t;

	// register indexes
	localparam logic [2:0] REG_FORCE_TARGET   = 3'd0;
	localparam logic [2:0] REG_INVERSE_MASS   = 3'd1;
	localparam logic [2:0] REG_DAMPING_GAIN   = 3'd2;
	localparam logic [2:0] REG_STIFFNESS_GAIN = 3'd3;
	localparam logic [2:0] REG_ACCEL_BLEND    = 3'd4;
	localparam logic [2:0] REG_VELOCITY_BLEND = 3'd5;
	localparam logic [2:0] REG_TICK_PERIOD_US = 3'd6;

	// sequencer phases, one multiply each
	localparam logic [3:0] P_PX   = 4'd0;
	localparam logic [3:0] P_PY   = 4'd1;
	localparam logic [3:0] P_PZ   = 4'd2;
	localparam logic [3:0] P_DMP  = 4'd3;
	localparam logic [3:0] P_STF  = 4'd4;
	localparam logic [3:0] P_INV  = 4'd5;
	localparam logic [3:0] P_BLA  = 4'd6;
	localparam logic [3:0] P_INTV = 4'd7;
	localparam logic [3:0] P_BLV  = 4'd8;
	localparam logic [3:0] P_INTX = 4'd9;
	localparam logic [3:0] P_OX   = 4'd10;
	localparam logic [3:0] P_OY   = 4'd11;
	localparam logic [3:0] P_OZ   = 4'd12;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	localparam int MUL_BITS = 25;
	localparam int DIV_BITS = 48;
	localparam logic [5:0] MUL_LAST = 6'(MUL_BITS - 1);
	localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);
	localparam logic [20:0] US_PER_S = 21'd1000000;
	localparam logic signed [23:0] DEADBAND_LSB = 24'sd13;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		else if (x < -64'sd2147483648) return 32'sh80000000;
		else return x[31:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
		if (x > 64'sd8388607) return 24'sh7fffff;
		else if (x < -64'sd8388608) return 24'sh800000;
		else return x[23:0];
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
		if (x > 64'sd549755813887) return 40'sh7fffffffff;
		else if (x < -64'sd549755813888) return 40'sh8000000000;
		else return x[39:0];
	endfunction

endpackage

// ===== rtl/core/axial_force_admittance_control.sv =====
// axial_force_admittance_control: top level, sequencer with bit-serial
// multiplier and bit-serial divider by one million
// depends on afac_pkg
//
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    in_data  (afac_pkg::in_beat_t)
// out       out  out_valid/out_ready  out_data (afac_pkg::out_beat_t)
// config    in   wr_en                wr_index, wr_data
//
// one beat runs 13 multiply phases (an operand load, then 25 multiplier
// bits, one per cycle) and two divisions of 48 quotient bits (one
// quotient bit per cycle), then hands the result over to the result
// register.
// reset clears the state, the result valid and sets registers to defaults.
// a result waiting on out_ready holds the sequencer in its output step;
// the next input beat is taken as soon as the sequencer is idle.
module axial_force_admittance_control (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  afac_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output afac_pkg::out_beat_t  out_data,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [23:0]          wr_data
);

	// configuration registers
	logic signed [23:0] force_target_q;
	logic [23:0]        inverse_mass_q;
	logic [23:0]        damping_gain_q;
	logic [23:0]        stiffness_gain_q;
	logic [16:0]        accel_blend_q;
	logic [16:0]        velocity_blend_q;
	logic [15:0]        tick_period_us_q;

	// controller state
	logic signed [31:0] fa_q;   // filtered acceleration
	logic signed [31:0] v_q;    // axial velocity
	logic signed [31:0] x_q;    // axial offset

	// working registers
	afac_pkg::in_beat_t  in_q;
	afac_pkg::out_beat_t cmd_q;
	afac_pkg::out_beat_t out_q;
	logic                out_valid_q;
	afac_pkg::state_t    state_q;
	logic [3:0]          phase_q;
	logic [5:0]          cnt_q;
	logic signed [63:0]  t_q;    // projection sum, then pre-filter velocity
	logic signed [23:0]  e_q;    // force error after deadband
	logic signed [63:0]  n_q;    // net force
	logic signed [31:0]  a_q;    // raw acceleration

	// bit-serial multiplier
	logic signed [63:0]  md_q;
	logic [24:0]         mr_q;
	logic signed [63:0]  acc_q;
	logic signed [63:0]  md_ld;
	logic [24:0]         mr_ld;
	logic signed [63:0]  addend;
	logic signed [63:0]  prod;

	// bit-serial divider
	logic [47:0]         dv_q;
	logic [19:0]         rem_q;
	logic                neg_q;
	logic [20:0]         rem_sh;
	logic                q_bit;
	logic [47:0]         dv_nx;
	logic signed [63:0]  quot;

	logic [16:0]         ab_eff;
	logic [16:0]         vb_eff;
	logic signed [63:0]  proj;
	logic signed [23:0]  err;
	logic signed [63:0]  net_sum;
	logic signed [63:0]  prod_mag;

	// blend weights above one act as one
	assign ab_eff = (accel_blend_q > afac_pkg::ONE_Q16) ? afac_pkg::ONE_Q16 : accel_blend_q;
	assign vb_eff = (velocity_blend_q > afac_pkg::ONE_Q16) ? afac_pkg::ONE_Q16
		: velocity_blend_q;

	// operands for the phase about to run
	always_comb begin
		md_ld = '0;
		mr_ld = '0;
		unique case (phase_q)
			afac_pkg::P_PX: begin
				md_ld = 64'(in_q.force_x);
				mr_ld = 25'(in_q.axis_x);
			end
			afac_pkg::P_PY: begin
				md_ld = 64'(in_q.force_y);
				mr_ld = 25'(in_q.axis_y);
			end
			afac_pkg::P_PZ: begin
				md_ld = 64'(in_q.force_z);
				mr_ld = 25'(in_q.axis_z);
			end
			afac_pkg::P_DMP: begin
				md_ld = 64'(v_q);
				mr_ld = {1'b0, damping_gain_q};
			end
			afac_pkg::P_STF: begin
				md_ld = 64'(x_q);
				mr_ld = {1'b0, stiffness_gain_q};
			end
			afac_pkg::P_INV: begin
				md_ld = n_q;
				mr_ld = {1'b0, inverse_mass_q};
			end
			afac_pkg::P_BLA: begin
				// w*(fresh-old) + old*2^16 equals the two-term blend
				md_ld = 64'(a_q) - 64'(fa_q);
				mr_ld = {8'b0, ab_eff};
			end
			afac_pkg::P_INTV: begin
				md_ld = 64'(fa_q);
				mr_ld = {9'b0, tick_period_us_q};
			end
			afac_pkg::P_BLV: begin
				md_ld = t_q - 64'(v_q);
				mr_ld = {8'b0, vb_eff};
			end
			afac_pkg::P_INTX: begin
				md_ld = 64'(v_q);
				mr_ld = {9'b0, tick_period_us_q};
			end
			afac_pkg::P_OX: begin
				md_ld = 64'(v_q);
				mr_ld = 25'(in_q.axis_x);
			end
			afac_pkg::P_OY: begin
				md_ld = 64'(v_q);
				mr_ld = 25'(in_q.axis_y);
			end
			afac_pkg::P_OZ: begin
				md_ld = 64'(v_q);
				mr_ld = 25'(in_q.axis_z);
			end
			default: begin
				md_ld = '0;
				mr_ld = '0;
			end
		endcase
	end

	// one multiplier bit per cycle, the top bit carries negative weight
	always_comb begin
		if (!mr_q[0]) addend = '0;
		else if (cnt_q == afac_pkg::MUL_LAST) addend = -md_q;
		else addend = md_q;
		prod = acc_q + addend;
	end

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q, dv_q[47]};
		q_bit  = (rem_sh >= afac_pkg::US_PER_S);
		dv_nx  = {dv_q[46:0], q_bit};
		quot   = neg_q ? -$signed({16'b0, dv_nx}) : $signed({16'b0, dv_nx});
	end

	// projection end, error with saturation and deadband
	always_comb begin
		proj = (t_q + prod) >>> 14;
		err  = afac_pkg::sat24(64'(force_target_q) - proj);
		if (err > -afac_pkg::DEADBAND_LSB && err < afac_pkg::DEADBAND_LSB) err = '0;
		net_sum  = n_q - (prod >>> 8);
		prod_mag = prod[63] ? -prod : prod;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_target_q   <= '0;
			inverse_mass_q   <= 24'd65536;
			damping_gain_q   <= '0;
			stiffness_gain_q <= '0;
			accel_blend_q    <= afac_pkg::ONE_Q16;
			velocity_blend_q <= afac_pkg::ONE_Q16;
			tick_period_us_q <= 16'd1000;
		end else if (wr_en) begin
			unique case (wr_index)
				afac_pkg::REG_FORCE_TARGET:   force_target_q   <= wr_data;
				afac_pkg::REG_INVERSE_MASS:   inverse_mass_q   <= wr_data;
				afac_pkg::REG_DAMPING_GAIN:   damping_gain_q   <= wr_data;
				afac_pkg::REG_STIFFNESS_GAIN: stiffness_gain_q <= wr_data;
				afac_pkg::REG_ACCEL_BLEND:    accel_blend_q    <= wr_data[16:0];
				afac_pkg::REG_VELOCITY_BLEND: velocity_blend_q <= wr_data[16:0];
				afac_pkg::REG_TICK_PERIOD_US: tick_period_us_q <= wr_data[15:0];
				default: ;   // unmapped index, ignored
			endcase
		end
	end

	// result valid: set on hand-over, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == afac_pkg::S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= afac_pkg::S_IDLE;
			phase_q     <= afac_pkg::P_PX;
			cnt_q       <= '0;
			fa_q        <= '0;
			v_q         <= '0;
			x_q         <= '0;
		end else begin
			unique case (state_q)
				afac_pkg::S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_data;
						phase_q <= afac_pkg::P_PX;
						state_q <= afac_pkg::S_LOAD;
					end
				end
				afac_pkg::S_LOAD: begin
					md_q    <= md_ld;
					mr_q    <= mr_ld;
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= afac_pkg::S_MUL;
				end
				afac_pkg::S_MUL: begin
					acc_q <= prod;
					md_q  <= md_q <<< 1;
					mr_q  <= {1'b0, mr_q[24:1]};
					if (cnt_q != afac_pkg::MUL_LAST) begin
						cnt_q <= cnt_q + 6'd1;
					end else begin
						cnt_q <= '0;
						unique case (phase_q)
							afac_pkg::P_PX:  t_q <= prod;
							afac_pkg::P_PY:  t_q <= t_q + prod;
							afac_pkg::P_PZ:  e_q <= err;
							afac_pkg::P_DMP: n_q <= ($signed(64'(e_q)) <<< 19) - (prod >>> 12);
							afac_pkg::P_STF: n_q <= 64'(afac_pkg::sat40(net_sum >>> 4));
							afac_pkg::P_INV: a_q <= afac_pkg::sat32(prod >>> 12);
							afac_pkg::P_BLA:
								fa_q <= afac_pkg::sat32((prod + (64'(fa_q) <<< 16)) >>> 16);
							afac_pkg::P_BLV:
								v_q <= afac_pkg::sat32((prod + (64'(v_q) <<< 16)) >>> 16);
							afac_pkg::P_OX: cmd_q.cmd_vel_x <= afac_pkg::sat32(prod >>> 14);
							afac_pkg::P_OY: cmd_q.cmd_vel_y <= afac_pkg::sat32(prod >>> 14);
							afac_pkg::P_OZ: cmd_q.cmd_vel_z <= afac_pkg::sat32(prod >>> 14);
							afac_pkg::P_INTV, afac_pkg::P_INTX: begin
								// integration phases: divide the product by one million
								neg_q <= prod[63];
								dv_q  <= prod_mag[47:0];
								rem_q <= '0;
							end
							default: ;
						endcase
						if (phase_q == afac_pkg::P_INTV || phase_q == afac_pkg::P_INTX) begin
							state_q <= afac_pkg::S_DIV;
						end else if (phase_q == afac_pkg::P_OZ) begin
							state_q <= afac_pkg::S_OUT;
						end else begin
							state_q <= afac_pkg::S_LOAD;
							phase_q <= phase_q + 4'd1;
						end
					end
				end
				afac_pkg::S_DIV: begin
					dv_q  <= dv_nx;
					rem_q <= q_bit ? 20'(rem_sh - afac_pkg::US_PER_S) : rem_sh[19:0];
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == afac_pkg::DIV_LAST) begin
						state_q <= afac_pkg::S_LOAD;
						phase_q <= phase_q + 4'd1;
						if (phase_q == afac_pkg::P_INTV) t_q <= 64'(afac_pkg::sat32(64'(v_q) + quot));
						else x_q <= afac_pkg::sat32(64'(x_q) + quot);
					end
				end
				afac_pkg::S_OUT: begin
					// result register free or emptied this cycle
					if (!out_valid_q || out_ready) begin
						out_q   <= cmd_q;
						state_q <= afac_pkg::S_IDLE;
					end
				end
				default: state_q <= afac_pkg::S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == afac_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// an accepted beat goes straight to operand load
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == afac_pkg::S_LOAD && phase_q == afac_pkg::P_PX)
		else $error("accepted beat did not start the sequencer");

	// divider only runs for the two integration phases
	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == afac_pkg::S_DIV |-> phase_q == afac_pkg::P_INTV
			|| phase_q == afac_pkg::P_INTX)
		else $error("divider active outside an integration phase");

	// multiplier count stays within the operand width
	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == afac_pkg::S_MUL |-> cnt_q <= afac_pkg::MUL_LAST)
		else $error("multiplier count overran");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_q))
		else $error("waiting result overwritten");

endmodule

// ===== test/axial_force_admittance_control_tb.sv =====
// axial_force_admittance_control_tb: self-checking bench for the axial force
// admittance controller, with a cycle-free predictor of the control law
// depends on afac_pkg and axial_force_admittance_control
`timescale 1ns / 100ps

module axial_force_admittance_control_tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint MICROS_PER_S = 1000000;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	afac_pkg::in_beat_t  in_data;
	logic                out_valid;
	logic                out_ready;
	afac_pkg::out_beat_t out_data;
	logic                wr_en;
	logic [2:0]          wr_index;
	logic [23:0]         wr_data;

	axial_force_admittance_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	// shadow registers, same masking as the block
	longint tgt_force, inv_mass, damp_gain, stiff_gain, acc_blend, vel_blend, tick_us;
	// shadow control state, all Q4.27
	longint st_accel, st_vel, st_offset;

	afac_pkg::out_beat_t cmd_vel_due[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        fail_count;
	int        quiet_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// clamp to a signed width
	function automatic longint clamp_bits(longint x, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	// first-order blend, a weight above one acts as one
	function automatic longint mix_q16(longint w, longint fresh, longint old);
		longint wc;
		wc = (w > 65536) ? 65536 : w;
		return clamp_bits((wc * fresh + (65536 - wc) * old) >>> 16, 32);
	endfunction

	// one control tick: updates the shadow state and returns the commanded velocity
	function automatic afac_pkg::out_beat_t predict_cmd_vel(afac_pkg::in_beat_t b);
		longint f [3];
		longint ax [3];
		longint proj, err, net, acc, vtmp;
		afac_pkg::out_beat_t r;
		f[0] = b.force_x; f[1] = b.force_y; f[2] = b.force_z;
		ax[0] = b.axis_x; ax[1] = b.axis_y; ax[2] = b.axis_z;
		proj = (f[0] * ax[0] + f[1] * ax[1] + f[2] * ax[2]) >>> 14;
		err = clamp_bits(tgt_force - proj, 24);
		// deadband of 0.05 N
		if (err > -13 && err < 13) err = 0;
		net = err * 524288 - ((damp_gain * st_vel) >>> 12) - ((stiff_gain * st_offset) >>> 8);
		net = clamp_bits(net >>> 4, 40);
		acc = clamp_bits((net * inv_mass) >>> 12, 32);
		st_accel = mix_q16(acc_blend, acc, st_accel);
		// division truncates toward zero, as longint division does
		vtmp = clamp_bits(st_vel + (st_accel * tick_us) / MICROS_PER_S, 32);
		st_vel = mix_q16(vel_blend, vtmp, st_vel);
		st_offset = clamp_bits(st_offset + (st_vel * tick_us) / MICROS_PER_S, 32);
		r.cmd_vel_x = 32'(clamp_bits((st_vel * ax[0]) >>> 14, 32));
		r.cmd_vel_y = 32'(clamp_bits((st_vel * ax[1]) >>> 14, 32));
		r.cmd_vel_z = 32'(clamp_bits((st_vel * ax[2]) >>> 14, 32));
		return r;
	endfunction

	// register write, only called while the block is idle
	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			afac_pkg::REG_FORCE_TARGET:   tgt_force  = longint'(signed'(val));
			afac_pkg::REG_INVERSE_MASS:   inv_mass   = longint'(val);
			afac_pkg::REG_DAMPING_GAIN:   damp_gain  = longint'(val);
			afac_pkg::REG_STIFFNESS_GAIN: stiff_gain = longint'(val);
			afac_pkg::REG_ACCEL_BLEND:    acc_blend  = longint'(val[16:0]);
			afac_pkg::REG_VELOCITY_BLEND: vel_blend  = longint'(val[16:0]);
			afac_pkg::REG_TICK_PERIOD_US: tick_us    = longint'(val[15:0]);
			default: ; // out of range index is ignored
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// sends one beat; valid stays high into the next beat unless a gap is drawn
	task automatic send_tick(afac_pkg::in_beat_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cmd_vel_due.push_back(predict_cmd_vel(b));
	endtask

	// sender holds off until every result is back and the sequencer is idle
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (cmd_vel_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic afac_pkg::in_beat_t make_tick(int fx, int fy, int fz,
		int axx, int axy, int axz);
		afac_pkg::in_beat_t b;
		b.force_x = 24'(fx); b.force_y = 24'(fy); b.force_z = 24'(fz);
		b.axis_x = 16'(axx); b.axis_y = 16'(axy); b.axis_z = 16'(axz);
		return b;
	endfunction

	function automatic logic [23:0] rand_force;
		case ($urandom_range(5))
			0: return 24'($urandom);
			1: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
			2: return 24'($signed($urandom_range(40)) - 20); // around the deadband
			default: return 24'($signed($urandom_range(16000)) - 8000);
		endcase
	endfunction

	function automatic logic [15:0] rand_axis;
		case ($urandom_range(7))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic [23:0] rand_gain(logic [23:0] typical);
		case ($urandom_range(7))
			0: return 24'hffffff;
			1: return 24'd0;
			2: return 24'($urandom);
			default: return 24'($urandom_range(32'(typical)));
		endcase
	endfunction

	// -- test tasks --

	// defaults after reset, field extremes, axis outside unit length
	task automatic test_defaults_and_extremes;
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(8388607, 8388607, 8388607, 16384, 16384, 16384));
		send_tick(make_tick(-8388608, -8388608, -8388608, -16384, -16384, -16384));
		send_tick(make_tick(-8388608, 8388607, -8388608, 32767, -32768, 32767));
		send_tick(make_tick(1000, -2000, 3000, -32768, 32767, -32768));
		send_tick(make_tick(-1, -1, -1, -1, -1, -1));
		drain();
	endtask

	// error just inside and just outside the 0.05 N band, both signs
	task automatic test_deadband;
		write_reg(afac_pkg::REG_FORCE_TARGET, 24'd0);
		send_tick(make_tick(0, 0, 12, 0, 0, 16384));
		send_tick(make_tick(0, 0, 13, 0, 0, 16384));
		send_tick(make_tick(0, 0, -12, 0, 0, 16384));
		send_tick(make_tick(0, 0, -13, 0, 0, 16384));
		drain();
	endtask

	// weights above one, zero weights, zero and longest tick
	task automatic test_blend_and_tick;
		write_reg(afac_pkg::REG_ACCEL_BLEND, 24'h01ffff);
		write_reg(afac_pkg::REG_VELOCITY_BLEND, 24'd65537);
		write_reg(afac_pkg::REG_TICK_PERIOD_US, 24'd0);
		send_tick(make_tick(5000, 0, 0, 16384, 0, 0));
		drain();
		write_reg(afac_pkg::REG_ACCEL_BLEND, 24'd0);
		write_reg(afac_pkg::REG_VELOCITY_BLEND, 24'd0);
		write_reg(afac_pkg::REG_TICK_PERIOD_US, 24'hffff);
		send_tick(make_tick(5000, 0, 0, 16384, 0, 0));
		drain();
		write_reg(afac_pkg::REG_ACCEL_BLEND, 24'd32768);
		write_reg(afac_pkg::REG_VELOCITY_BLEND, 24'd65536);
		send_tick(make_tick(-5000, 100, 0, 16384, 0, 0));
		send_tick(make_tick(-5000, 100, 0, 16384, 0, 0));
		drain();
	endtask

	// every stage driven into its limits; out of range index is ignored
	task automatic test_saturation;
		write_reg(REG_UNMAPPED, 24'hffffff);
		write_reg(afac_pkg::REG_FORCE_TARGET, 24'h7fffff);
		write_reg(afac_pkg::REG_INVERSE_MASS, 24'hffffff);
		write_reg(afac_pkg::REG_DAMPING_GAIN, 24'hffffff);
		write_reg(afac_pkg::REG_STIFFNESS_GAIN, 24'hffffff);
		send_tick(make_tick(-8388608, 0, 0, 16384, 0, 0));
		send_tick(make_tick(-8388608, 0, 0, 16384, 0, 0));
		drain();
		write_reg(afac_pkg::REG_FORCE_TARGET, 24'h800000);
		write_reg(afac_pkg::REG_INVERSE_MASS, 24'd0);
		send_tick(make_tick(8388607, 0, 0, 16384, 0, 0));
		drain();
		write_reg(afac_pkg::REG_INVERSE_MASS, 24'd65536);
		write_reg(afac_pkg::REG_DAMPING_GAIN, 24'd0);
		write_reg(afac_pkg::REG_STIFFNESS_GAIN, 24'd0);
		write_reg(afac_pkg::REG_FORCE_TARGET, 24'd0);
		drain();
	endtask

	// batches of random ticks, fresh register settings between batches
	task automatic test_random_ticks(int batches);
		int n;
		for (int k = 0; k < batches; k++) begin
			write_reg(afac_pkg::REG_FORCE_TARGET, $urandom_range(3) == 0 ? 24'($urandom)
				: 24'($signed($urandom_range(8000)) - 4000));
			write_reg(afac_pkg::REG_INVERSE_MASS, rand_gain(24'd200000));
			write_reg(afac_pkg::REG_DAMPING_GAIN, rand_gain(24'd100000));
			write_reg(afac_pkg::REG_STIFFNESS_GAIN, rand_gain(24'd100000));
			write_reg(afac_pkg::REG_ACCEL_BLEND,
				$urandom_range(5) == 0 ? 24'($urandom_range(131071))
				: 24'($urandom_range(65536)));
			write_reg(afac_pkg::REG_VELOCITY_BLEND,
				$urandom_range(5) == 0 ? 24'($urandom_range(131071))
				: 24'($urandom_range(65536)));
			write_reg(afac_pkg::REG_TICK_PERIOD_US,
				$urandom_range(7) == 0 ? 24'($urandom_range(65535))
				: 24'($urandom_range(2000)));
			if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, 24'($urandom));
			n = $urandom_range(30, 60);
			for (int i = 0; i < n; i++)
				send_tick(make_tick(int'(signed'(rand_force())), int'(signed'(rand_force())),
					int'(signed'(rand_force())), int'(signed'(rand_axis())),
					int'(signed'(rand_axis())), int'(signed'(rand_axis()))));
			drain();
		end
	endtask

	// receiver: random back-pressure and result checking
	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		afac_pkg::out_beat_t want;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (cmd_vel_due.size() == 0) begin
					$error("result beat with no tick outstanding");
					fail_count++;
				end else begin
					want = cmd_vel_due.pop_front();
					check_field("cmd_vel_x", want.cmd_vel_x, out_data.cmd_vel_x);
					check_field("cmd_vel_y", want.cmd_vel_y, out_data.cmd_vel_y);
					check_field("cmd_vel_z", want.cmd_vel_z, out_data.cmd_vel_z);
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		wr_en     <= 1'b0;
		wr_index  <= '0;
		wr_data   <= '0;
		quiet_cycles <= 0;
		fail_count = 0;
		send_idle_pct = 35;
		recv_idle_pct = 53;
		tgt_force = 0; inv_mass = 65536; damp_gain = 0; stiff_gain = 0;
		acc_blend = 65536; vel_blend = 65536; tick_us = 1000;
		st_accel = 0; st_vel = 0; st_offset = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_and_extremes();
		test_deadband();
		test_blend_and_tick();
		test_saturation();
		test_random_ticks(7);
		send_idle_pct = 53;
		recv_idle_pct = 35;
		test_random_ticks(7);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_ticks(7);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && cmd_vel_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/afac_pkg.sv
rtl/core/axial_force_admittance_control.sv
test/axial_force_admittance_control_tb.sv
